### src/hvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared types, constants and the arctangent table of the haversine core.
// ----------------------------------------------------------------------------
package hvd_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 23;
	localparam int CORDIC_STAGES_DEF   = 24;

	// angle differences are exact at 33 bits
	localparam int ANG_W = 33;
	// CORDIC datapath width, Q30 values with headroom
	localparam int XW    = 36;

	localparam logic [30:0] Q30_ONE          = 31'h4000_0000;
	localparam logic [30:0] CORDIC_INV_GAIN  = 31'd652032874;
	localparam logic [30:0] DEG_TO_RAD_Q36   = 31'd1199381129;
	localparam logic [22:0] EARTH_RADIUS_M   = 23'd6367000;
	localparam logic [28:0] DIST_MAX         = 29'h1FFF_FFFF;

	// floor(x/360) = (x * RECIP_360) >> 26, exact for x < 2^17
	localparam logic [17:0] RECIP_360        = 18'd186414;

	// square root: 31 root bits from a 62-bit radicand
	localparam int SQ_RAD_W  = 62;
	localparam int SQ_ROOT_W = 31;
	localparam int SQ_REM_W  = 34;
	localparam int SQ_CELLS  = 31;

	typedef enum logic [0:0] {
		REG_REF_LAT = 1'b0,
		REG_REF_LON = 1'b1
	} cfg_idx_t;

	// atan(2^-i) in Q30, rounded to nearest
	function automatic logic [30:0] atan_q30(input logic [4:0] i);
		logic [30:0] v;
		unique case (i)
			5'd0:  v = 31'd843314857;
			5'd1:  v = 31'd497837829;
			5'd2:  v = 31'd263043837;
			5'd3:  v = 31'd133525159;
			5'd4:  v = 31'd67021687;
			5'd5:  v = 31'd33543516;
			5'd6:  v = 31'd16775851;
			5'd7:  v = 31'd8388437;
			5'd8:  v = 31'd4194283;
			5'd9:  v = 31'd2097149;
			5'd10: v = 31'd1048576;
			5'd11: v = 31'd524288;
			5'd12: v = 31'd262144;
			5'd13: v = 31'd131072;
			5'd14: v = 31'd65536;
			5'd15: v = 31'd32768;
			5'd16: v = 31'd16384;
			5'd17: v = 31'd8192;
			5'd18: v = 31'd4096;
			5'd19: v = 31'd2048;
			5'd20: v = 31'd1024;
			5'd21: v = 31'd512;
			5'd22: v = 31'd256;
			5'd23: v = 31'd128;
			5'd24: v = 31'd64;
			5'd25: v = 31'd32;
			5'd26: v = 31'd16;
			5'd27: v = 31'd8;
			5'd28: v = 31'd4;
			5'd29: v = 31'd2;
			5'd30: v = 31'd1;
			5'd31: v = 31'd1;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### src/hvd_angle_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_angle_prep
// Reduces a fixed-point degree angle to the first quadrant and converts it
// to Q30 radians. Four pipeline stages.
// ----------------------------------------------------------------------------
module hvd_angle_prep #(
	parameter int FRAC = 24
) (
	input  logic                          clk,
	input  logic signed [hvd_pkg::ANG_W-1:0] angle,
	output logic signed [hvd_pkg::XW-1:0]    z,
	output logic                          neg
);
	import hvd_pkg::*;

	localparam int MW = ANG_W;
	localparam logic [MW-1:0] FULL    = MW'(360) << FRAC;
	localparam logic [MW-1:0] HALF    = MW'(180) << FRAC;
	localparam logic [MW-1:0] QUARTER = MW'(90) << FRAC;
	localparam logic [MW-1:0] LO_MASK = (MW'(1) << FRAC) - MW'(1);

	logic [MW-1:0] mag_s1;
	logic [8:0]    q_s1;
	logic [MW-1:0] mred_s2;
	logic [30:0]   mfold_s3;
	logic          neg_s3;
	logic [30:0]   z_s4;
	logic          neg_s4;

	logic [MW-1:0] mag;
	logic [16:0]   hi;
	logic [34:0]   qprod;
	logic [16:0]   hi2;
	logic [16:0]   qx;
	logic [8:0]    rem360;
	logic [MW-1:0] m1;
	logic [MW-1:0] m2;
	logic          ng;
	logic [61:0]   zprod;

	always_comb begin
		mag   = angle[ANG_W-1] ? MW'(-angle) : MW'(angle);
		hi    = 17'(mag >> FRAC);
		qprod = 35'(hi) * 35'(RECIP_360);
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		q_s1   <= 9'(qprod >> 26);
	end

	// remainder of the whole-degree part modulo 360
	always_comb begin
		hi2    = 17'(mag_s1 >> FRAC);
		qx     = 17'(q_s1) * 17'(360);
		rem360 = 9'(hi2 - qx);
	end

	always_ff @(posedge clk) begin
		mred_s2 <= (MW'(rem360) << FRAC) | (mag_s1 & LO_MASK);
	end

	always_comb begin
		m1 = (mred_s2 > HALF) ? FULL - mred_s2 : mred_s2;
		ng = 1'b0;
		m2 = m1;
		if (m1 > QUARTER) begin
			m2 = HALF - m1;
			ng = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mfold_s3 <= 31'(m2);
		neg_s3   <= ng;
	end

	always_comb begin
		zprod = 62'(mfold_s3) * 62'(DEG_TO_RAD_Q36);
	end

	always_ff @(posedge clk) begin
		z_s4   <= 31'(zprod >> (FRAC + 6));
		neg_s4 <= neg_s3;
	end

	assign z   = XW'(signed'({1'b0, z_s4}));
	assign neg = neg_s4;

endmodule
`default_nettype wire

### src/hvd_rot_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_rot_cell
// One CORDIC rotation-mode iteration, registered.
// ----------------------------------------------------------------------------
module hvd_rot_cell #(
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic signed [hvd_pkg::XW-1:0] x_in,
	input  logic signed [hvd_pkg::XW-1:0] y_in,
	input  logic signed [hvd_pkg::XW-1:0] z_in,
	input  logic                          neg_in,
	output logic signed [hvd_pkg::XW-1:0] x_out,
	output logic signed [hvd_pkg::XW-1:0] y_out,
	output logic signed [hvd_pkg::XW-1:0] z_out,
	output logic                          neg_out
);
	import hvd_pkg::*;

	localparam logic signed [XW-1:0] ATAN = XW'(signed'({1'b0, atan_q30(5'(SHIFT))}));

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign dx = y_in >>> SHIFT;
	assign dy = x_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (!z_in[XW-1]) begin
			x_out <= x_in - dx;
			y_out <= y_in + dy;
			z_out <= z_in - ATAN;
		end else begin
			x_out <= x_in + dx;
			y_out <= y_in - dy;
			z_out <= z_in + ATAN;
		end
		neg_out <= neg_in;
	end

endmodule
`default_nettype wire

### src/hvd_vec_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_vec_cell
// One CORDIC vectoring-mode iteration, registered.
// ----------------------------------------------------------------------------
module hvd_vec_cell #(
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic signed [hvd_pkg::XW-1:0] x_in,
	input  logic signed [hvd_pkg::XW-1:0] y_in,
	input  logic signed [hvd_pkg::XW-1:0] z_in,
	output logic signed [hvd_pkg::XW-1:0] x_out,
	output logic signed [hvd_pkg::XW-1:0] y_out,
	output logic signed [hvd_pkg::XW-1:0] z_out
);
	import hvd_pkg::*;

	localparam logic signed [XW-1:0] ATAN = XW'(signed'({1'b0, atan_q30(5'(SHIFT))}));

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign dx = y_in >>> SHIFT;
	assign dy = x_in >>> SHIFT;

	always_ff @(posedge clk) begin
		if (!y_in[XW-1]) begin
			x_out <= x_in + dx;
			y_out <= y_in - dy;
			z_out <= z_in + ATAN;
		end else begin
			x_out <= x_in - dx;
			y_out <= y_in + dy;
			z_out <= z_in - ATAN;
		end
	end

endmodule
`default_nettype wire

### src/hvd_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_sqrt_cell
// One digit of a restoring integer square root: two radicand bits in,
// one root bit out, registered.
// ----------------------------------------------------------------------------
module hvd_sqrt_cell (
	input  logic                               clk,
	input  logic [hvd_pkg::SQ_RAD_W-1:0]       rad_in,
	input  logic [hvd_pkg::SQ_REM_W-1:0]       rem_in,
	input  logic [hvd_pkg::SQ_ROOT_W-1:0]      root_in,
	output logic [hvd_pkg::SQ_RAD_W-1:0]       rad_out,
	output logic [hvd_pkg::SQ_REM_W-1:0]       rem_out,
	output logic [hvd_pkg::SQ_ROOT_W-1:0]      root_out
);
	import hvd_pkg::*;

	logic [SQ_REM_W-1:0] rem_n;
	logic [SQ_REM_W-1:0] trial;
	logic                fits;

	always_comb begin
		rem_n = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
		trial = {1'b0, root_in, 2'b01};
		fits  = rem_n >= trial;
	end

	always_ff @(posedge clk) begin
		rad_out  <= {rad_in[SQ_RAD_W-3:0], 2'b00};
		rem_out  <= fits ? rem_n - trial : rem_n;
		root_out <= {root_in[SQ_ROOT_W-2:0], fits};
	end

endmodule
`default_nettype wire

### src/haversine_distance_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_distance_core
// Great-circle distance from a configured reference position to each target.
// ----------------------------------------------------------------------------
// Fully pipelined: one target is taken every cycle (busy is always low) and
// its distance appears with a one-cycle done strobe. A target passes
// in order through the angle reduction, the sine/cosine CORDIC
// chain, the product stages, the 31-digit square root chain,
// the arctangent CORDIC chain and the final scaling.
// Results cannot be held off; capture distance whenever done is high. Reference
// registers should be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module haversine_distance_core #(
	parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = hvd_pkg::CORDIC_STAGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [30:0]  target_latitude,
	input  logic signed [31:0]  target_longitude,
	input  logic                cfg_we,
	input  hvd_pkg::cfg_idx_t   cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                done,
	output logic [28:0]         distance
);
	import hvd_pkg::*;

	localparam int CS     = CORDIC_STAGES;
	localparam int LAT    = 2 * CS + 41;
	localparam int SQ_TAP = CS + 38;

	logic signed [30:0] ref_lat_q;
	logic signed [31:0] ref_lon_q;
	logic [LAT-1:0]     vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REF_LAT: ref_lat_q <= signed'(cfg_data[30:0]);
				REG_REF_LON: ref_lon_q <= signed'(cfg_data);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign busy = 1'b0;

	// angles: half dlat, half dlon (one more fraction bit), ref lat, target lat
	logic signed [ANG_W-1:0] ang_s1 [4];

	always_ff @(posedge clk) begin
		ang_s1[0] <= ANG_W'(target_latitude) - ANG_W'(ref_lat_q);
		ang_s1[1] <= ANG_W'(target_longitude) - ANG_W'(ref_lon_q);
		ang_s1[2] <= ANG_W'(ref_lat_q);
		ang_s1[3] <= ANG_W'(target_latitude);
	end

	logic signed [XW-1:0] rot_x [4][CS+1];
	logic signed [XW-1:0] rot_y [4][CS+1];
	logic signed [XW-1:0] rot_z [4][CS+1];
	logic                 rot_n [4][CS+1];

	for (genvar a = 0; a < 4; a++) begin : g_ang
		hvd_angle_prep #(
			.FRAC((a < 2) ? ANGLE_FRAC_BITS + 1 : ANGLE_FRAC_BITS)
		) u_prep (
			.clk  (clk),
			.angle(ang_s1[a]),
			.z    (rot_z[a][0]),
			.neg  (rot_n[a][0])
		);
		assign rot_x[a][0] = XW'(signed'({1'b0, CORDIC_INV_GAIN}));
		assign rot_y[a][0] = '0;

		for (genvar k = 0; k < CS; k++) begin : g_rot
			hvd_rot_cell #(.SHIFT(k)) u_cell (
				.clk    (clk),
				.x_in   (rot_x[a][k]),
				.y_in   (rot_y[a][k]),
				.z_in   (rot_z[a][k]),
				.neg_in (rot_n[a][k]),
				.x_out  (rot_x[a][k+1]),
				.y_out  (rot_y[a][k+1]),
				.z_out  (rot_z[a][k+1]),
				.neg_out(rot_n[a][k+1])
			);
		end
	end

	// a = sh^2 + (c1*c2)*sl^2, each product floored to Q30
	logic signed [XW-1:0] c1_full;
	logic signed [XW-1:0] c2_full;
	logic signed [31:0]   sh;
	logic signed [31:0]   sl;
	logic signed [31:0]   c1;
	logic signed [31:0]   c2;

	always_comb begin
		c1_full = rot_n[2][CS] ? -rot_x[2][CS] : rot_x[2][CS];
		c2_full = rot_n[3][CS] ? -rot_x[3][CS] : rot_x[3][CS];
		sh = signed'(rot_y[0][CS][31:0]);
		sl = signed'(rot_y[1][CS][31:0]);
		c1 = signed'(c1_full[31:0]);
		c2 = signed'(c2_full[31:0]);
	end

	logic signed [63:0] sqh_s1;
	logic signed [63:0] cc_s1;
	logic signed [63:0] sql_s1;

	always_ff @(posedge clk) begin
		sqh_s1 <= 64'(sh) * 64'(sh);
		cc_s1  <= 64'(c1) * 64'(c2);
		sql_s1 <= 64'(sl) * 64'(sl);
	end

	logic signed [31:0] cc_q30;
	logic signed [31:0] sql_q30;
	logic signed [33:0] t1_s2;
	logic signed [63:0] t2_s2;

	always_comb begin
		cc_q30  = 32'(cc_s1 >>> 30);
		sql_q30 = 32'(sql_s1 >>> 30);
	end

	always_ff @(posedge clk) begin
		t1_s2 <= 34'(sqh_s1 >>> 30);
		t2_s2 <= 64'(cc_q30) * 64'(sql_q30);
	end

	logic signed [34:0] a_sum;
	logic [30:0]        a_s3;

	always_comb begin
		a_sum = 35'(t1_s2) + 35'(t2_s2 >>> 30);
	end

	always_ff @(posedge clk) begin
		if (a_sum[34]) begin
			a_s3 <= '0;
		end else if (a_sum > 35'(Q30_ONE)) begin
			a_s3 <= Q30_ONE;
		end else begin
			a_s3 <= 31'(a_sum);
		end
	end

	// sqrt(a) and sqrt(1-a), both in Q30
	logic [SQ_RAD_W-1:0]  sq_rad  [2][SQ_CELLS+1];
	logic [SQ_REM_W-1:0]  sq_rem  [2][SQ_CELLS+1];
	logic [SQ_ROOT_W-1:0] sq_root [2][SQ_CELLS+1];

	assign sq_rad[0][0]  = {1'b0, a_s3, 30'b0};
	assign sq_rad[1][0]  = {1'b0, Q30_ONE - a_s3, 30'b0};

	for (genvar r = 0; r < 2; r++) begin : g_sq
		assign sq_rem[r][0]  = '0;
		assign sq_root[r][0] = '0;
		for (genvar k = 0; k < SQ_CELLS; k++) begin : g_cell
			hvd_sqrt_cell u_cell (
				.clk     (clk),
				.rad_in  (sq_rad[r][k]),
				.rem_in  (sq_rem[r][k]),
				.root_in (sq_root[r][k]),
				.rad_out (sq_rad[r][k+1]),
				.rem_out (sq_rem[r][k+1]),
				.root_out(sq_root[r][k+1])
			);
		end
	end

	// c/2 = atan2(sqrt(a), sqrt(1-a))
	logic signed [XW-1:0] vec_x [CS+1];
	logic signed [XW-1:0] vec_y [CS+1];
	logic signed [XW-1:0] vec_z [CS+1];

	assign vec_x[0] = XW'(signed'({1'b0, sq_root[1][SQ_CELLS]}));
	assign vec_y[0] = XW'(signed'({1'b0, sq_root[0][SQ_CELLS]}));
	assign vec_z[0] = '0;

	for (genvar k = 0; k < CS; k++) begin : g_vec
		hvd_vec_cell #(.SHIFT(k)) u_cell (
			.clk  (clk),
			.x_in (vec_x[k]),
			.y_in (vec_y[k]),
			.z_in (vec_z[k]),
			.x_out(vec_x[k+1]),
			.y_out(vec_y[k+1]),
			.z_out(vec_z[k+1])
		);
	end

	// distance = z * R * 32 / 2^30 in sixteenths of a meter, rounded
	logic [31:0] z_pos;
	logic [54:0] prod_s1;
	logic [29:0] dist_r;
	logic [28:0] dist_q;

	assign z_pos = vec_z[CS][XW-1] ? '0 : vec_z[CS][31:0];

	always_ff @(posedge clk) begin
		prod_s1 <= 55'(z_pos) * 55'(EARTH_RADIUS_M);
	end

	assign dist_r = 30'((prod_s1 + 55'(1 << 24)) >> 25);

	always_ff @(posedge clk) begin
		dist_q <= (dist_r > 30'(DIST_MAX)) ? DIST_MAX : dist_r[28:0];
	end

	assign done     = vld_q[LAT-1];
	assign distance = dist_q;

`ifndef ASSERT_OFF
	logic [63:0] sq_sum;
	assign sq_sum = 64'(sq_root[0][SQ_CELLS]) * 64'(sq_root[0][SQ_CELLS])
		+ 64'(sq_root[1][SQ_CELLS]) * 64'(sq_root[1][SQ_CELLS]);

	// a result only ever comes from a transaction a fixed latency back
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without a matching start");

	// floor roots of a and 1-a square back to at most one and no less than one minus 2^-27
	a_sqrt_upper: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[SQ_TAP] |-> (sq_sum <= (64'(1) << 60)))
		else $error("square roots exceed unit circle");

	a_sqrt_lower: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[SQ_TAP] |-> (sq_sum >= ((64'(1) << 60) - (64'(1) << 33))))
		else $error("square roots fall short of unit circle");
`endif

endmodule
`default_nettype wire
